>>> hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, S-box and round helpers for the AES block encryptor.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int BLOCK_BITS = 128;
   localparam int KEY_BITS   = 32;
   localparam int INDEX_BITS = 6;
   localparam int COUNT_BITS = 4;

   localparam logic [COUNT_BITS-1:0] ROUNDS_MIN   = 4'd10;
   localparam logic [COUNT_BITS-1:0] ROUNDS_MAX   = 4'd14;
   localparam logic [COUNT_BITS-1:0] ROUNDS_RESET = 4'd14;

   localparam logic ACTION_LOAD    = 1'b0;
   localparam logic ACTION_ENCRYPT = 1'b1;

   // one word moving down the cell chain
   typedef struct packed {
      logic                  action;
      logic [INDEX_BITS-1:0] key_index;
      logic [KEY_BITS-1:0]   key_word;
      logic [BLOCK_BITS-1:0] state;
      logic                  last;
   } word_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes + ShiftRows, then optional MixColumns
   function automatic logic [BLOCK_BITS-1:0] round_fn(input logic [BLOCK_BITS-1:0] s,
                                                      input logic                  mix);
      logic [BLOCK_BITS-1:0] t;
      logic [BLOCK_BITS-1:0] m;
      logic [7:0] a0, a1, a2, a3, x;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(c*4+r) +: 8] = SBOX[s[8*(((c+r)%4)*4+r) +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[8*(c*4)   +: 8];
         a1 = t[8*(c*4+1) +: 8];
         a2 = t[8*(c*4+2) +: 8];
         a3 = t[8*(c*4+3) +: 8];
         x  = a0 ^ a1 ^ a2 ^ a3;
         m[8*(c*4)   +: 8] = a0 ^ x ^ xtime(a0 ^ a1);
         m[8*(c*4+1) +: 8] = a1 ^ x ^ xtime(a1 ^ a2);
         m[8*(c*4+2) +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
         m[8*(c*4+3) +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
      end
      round_fn = mix ? m : t;
   endfunction

endpackage

>>> hw/rtl/aes_cell.sv
// ----------------------------------------------------------------------------
// aes_cell
// One round cell: holds its four round-key words and one pipeline word.
// ----------------------------------------------------------------------------
module aes_cell #(
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [aes_pkg::COUNT_BITS-1:0]      rounds,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  aes_pkg::word_type                   up_word,
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output aes_pkg::word_type                   dn_word
);
   import aes_pkg::*;

   localparam logic [COUNT_BITS-1:0] CELL_NUM = COUNT_BITS'(INDEX);

   logic [KEY_BITS-1:0]   key_ff [4];
   logic                  valid_ff;
   word_type              word_ff;
   word_type              word_in;
   logic                  take;
   logic                  key_hit;
   logic [BLOCK_BITS-1:0] key_all;
   logic [BLOCK_BITS-1:0] rnd_out;

   assign up_ready = !valid_ff || dn_ready;
   assign take     = up_valid && up_ready;
   assign key_hit  = (up_word.action == ACTION_LOAD) &&
                     (up_word.key_index[INDEX_BITS-1:2] == CELL_NUM);
   assign key_all  = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};

   always_comb begin
      word_in = up_word;
      if (INDEX == 0) begin
         rnd_out = up_word.state ^ key_all;
      end else if (CELL_NUM <= rounds) begin
         rnd_out = round_fn(up_word.state, CELL_NUM < rounds) ^ key_all;
      end else begin
         rnd_out = up_word.state;
      end
      word_in.state = rnd_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
      if (take && key_hit) begin
         key_ff[up_word.key_index[1:0]] <= up_word.key_word;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

>>> hw/rtl/aes_block_encrypt.sv
// ----------------------------------------------------------------------------
// aes_block_encrypt
// AES forward cipher, ECB, as a chain of round cells with in-band key loads.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | content
//  req     | in  | req_tvalid / req_tready   | load key word or encrypt block
//  rsp     | out | rsp_tvalid / rsp_tready   | ciphertext block
//  csr     | in  | csr_we                    | round count
//
// One word per cycle unless a ciphertext stalled at rsp holds the chain; every cell registers the word.
// Key loads travel the chain and are written when they pass their cell, so
// loads and blocks stay in order. Loads give no output word.
// Synchronous reset empties the chain; key words are undefined until loaded.
// A stall at rsp fills the chain cell by cell before req_tready drops.
module aes_block_encrypt #(
   parameter int KEY_WORDS = 60
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,  // key_index, key_word, block_low, block_high, pad
   input  logic [0:0]   req_tuser,  // action
   input  logic         req_tlast,  // last_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // cipher_low, cipher_high
   output logic         rsp_tlast,  // last_out
   input  logic         csr_we,
   input  logic [3:0]   csr_wdata
);
   import aes_pkg::*;

   localparam int CELLS = KEY_WORDS / 4;
   localparam logic [COUNT_BITS-1:0] ROUND_LIMIT = COUNT_BITS'(KEY_WORDS / 4 - 1);

   logic [COUNT_BITS-1:0] rounds_ff;
   logic [COUNT_BITS-1:0] rounds_sat;
   logic [COUNT_BITS-1:0] rounds_eff;
   logic                  vld   [CELLS+1];
   logic                  rdy   [CELLS+1];
   word_type              wrd   [CELLS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff <= ROUNDS_RESET;
      end else if (csr_we) begin
         rounds_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (rounds_ff < ROUNDS_MIN) begin
         rounds_sat = ROUNDS_MIN;
      end else if (rounds_ff > ROUNDS_MAX) begin
         rounds_sat = ROUNDS_MAX;
      end else begin
         rounds_sat = rounds_ff;
      end
      rounds_eff = (rounds_sat > ROUND_LIMIT) ? ROUND_LIMIT : rounds_sat;
   end

   assign wrd[0]     = {req_tuser[0], req_tdata[5:0], req_tdata[37:6], req_tdata[165:38],
                        req_tlast};
   assign vld[0]     = req_tvalid;
   assign req_tready = rdy[0];

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      aes_cell #(.INDEX(j)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .rounds   (rounds_eff),
         .up_valid (vld[j]),
         .up_ready (rdy[j]),
         .up_word  (wrd[j]),
         .dn_valid (vld[j+1]),
         .dn_ready (rdy[j+1]),
         .dn_word  (wrd[j+1])
      );
   end

   // loads drop out at the end of the chain
   assign rdy[CELLS]  = (wrd[CELLS].action == ACTION_LOAD) || rsp_tready;
   assign rsp_tvalid  = vld[CELLS] && (wrd[CELLS].action == ACTION_ENCRYPT);
   assign rsp_tdata   = wrd[CELLS].state;
   assign rsp_tlast   = wrd[CELLS].last;

`ifndef SYNTHESIS
   a_load_drains: assert property (@(posedge clock) disable iff (reset)
      (vld[CELLS] && !rsp_tvalid) |-> rdy[CELLS - 1])
      else $error("load word blocked at chain end");
   a_out_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("chain stalled without output backpressure");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");
`endif

endmodule

>>> dv/aes_block_encrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_encrypt_checker
// Watches the req, rsp and csr channels of the AES block encryptor. It keeps
// its own copy of the round key store and the round count, enciphers every
// accepted block and compares each rsp word against the oldest expected one.
// ----------------------------------------------------------------------------
module aes_block_encrypt_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [167:0] req_tdata,  // key_index, key_word, block_low, block_high, pad
   input  logic [0:0]   req_tuser,  // action
   input  logic         req_tlast,  // last_block
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,  // cipher_low, cipher_high
   input  logic         rsp_tlast,  // last_out
   input  logic         csr_we,
   input  logic [3:0]   csr_wdata,
   output int           fail_count,
   output int           pending
);
   import aes_pkg::*;

   localparam int STORE_DEPTH = 60;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic        last;
   } cipher_word_type;

   cipher_word_type     cipher_queue[$];
   logic [31:0]         key_store[STORE_DEPTH];
   logic [COUNT_BITS-1:0] round_setting;
   logic [7:0]          sub_table[256];

   function automatic logic [7:0] gf_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_double(a);
      end
      return p;
   endfunction

   // S-box built from the field inverse and the affine map
   initial begin
      logic [7:0] inv;
      logic [15:0] d;
      for (int a = 0; a < 256; a++) begin
         inv = (a == 0) ? 8'h00 : 8'h01;
         if (a != 0) for (int i = 0; i < 254; i++) inv = gf_mul(inv, a[7:0]);
         d = {inv, inv};
         sub_table[a] = inv ^ d[14:7] ^ d[13:6] ^ d[12:5] ^ d[11:4] ^ 8'h63;
      end
   end

   function automatic int active_rounds();
      int r;
      r = round_setting;
      if (r < 10) r = 10;
      if (r > 14) r = 14;
      if (r > STORE_DEPTH / 4 - 1) r = STORE_DEPTH / 4 - 1;
      return r;
   endfunction

   function automatic logic [127:0] encipher(input logic [127:0] plain);
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] res;
      int nr;
      nr = active_rounds();
      for (int i = 0; i < 16; i++) s[i] = plain[8*i +: 8];
      for (int rnd = 0; rnd <= nr; rnd++) begin
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) t[c*4+r] = sub_table[s[((c+r)%4)*4+r]];
            s = t;
            if (rnd < nr) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
                  x  = a0 ^ a1 ^ a2 ^ a3;
                  s[c*4]   = a0 ^ x ^ gf_double(a0 ^ a1);
                  s[c*4+1] = a1 ^ x ^ gf_double(a1 ^ a2);
                  s[c*4+2] = a2 ^ x ^ gf_double(a2 ^ a3);
                  s[c*4+3] = a3 ^ x ^ gf_double(a3 ^ a0);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) s[c*4+r] ^= key_store[rnd*4+c][8*r +: 8];
      end
      for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
      return res;
   endfunction

   always @(posedge clock) begin
      cipher_word_type got;
      cipher_word_type want;
      logic [5:0] idx;
      if (reset) begin
         round_setting = ROUNDS_RESET;
         fail_count    = 0;
         cipher_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cipher_low  = rsp_tdata[63:0];
            got.cipher_high = rsp_tdata[127:64];
            got.last        = rsp_tlast;
            if (cipher_queue.size() == 0) begin
               $display("%0t: unexpected rsp word %h", $time, got);
               fail_count++;
            end else begin
               want = cipher_queue.pop_front();
               if (got.cipher_low !== want.cipher_low) begin
                  $display("%0t: cipher_low exp %h act %h", $time, want.cipher_low,
                           got.cipher_low);
                  fail_count++;
               end
               if (got.cipher_high !== want.cipher_high) begin
                  $display("%0t: cipher_high exp %h act %h", $time, want.cipher_high,
                           got.cipher_high);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last_out exp %b act %b", $time, want.last, got.last);
                  fail_count++;
               end
            end
         end
         if (csr_we) round_setting = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == ACTION_LOAD) begin
               idx = req_tdata[5:0];
               if (idx < STORE_DEPTH) key_store[idx] = req_tdata[37:6];
            end else begin
               {want.cipher_high, want.cipher_low} = encipher(req_tdata[165:38]);
               want.last = req_tlast;
               cipher_queue.push_back(want);
            end
         end
      end
      pending = cipher_queue.size();
   end

endmodule

>>> dv/tb_aes_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes_block_encrypt
// Stimulus for the AES block encryptor: key loads, directed and random
// blocks over several round counts, with random idling on both channels.
// The checker beside the block predicts and compares every ciphertext.
// ----------------------------------------------------------------------------
module tb_aes_block_encrypt;
   import aes_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 25;
   localparam int PHASE_WORDS = 148;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we;
   logic [3:0]   csr_wdata;
   int           fail_count;
   int           pending;
   int           cycles = 0;
   int           send_idle_pct;
   int           recv_idle_pct;
   bit           hold_request;

   aes_block_encrypt u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   aes_block_encrypt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_aes_block_encrypt: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_word(input logic act, input logic [5:0] idx, input logic [31:0] kw,
                            input logic [63:0] lo, input logic [63:0] hi, input logic last);
      int gap;
      logic rdy;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < 30) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tlast  <= last;
      req_tdata  <= {2'b00, hi, lo, kw, idx};
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_rounds(input logic [3:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_random();
      logic [5:0] idx;
      if ($urandom_range(0, 99) < 25) begin
         idx = 6'($urandom_range(0, 63));
         send_word(ACTION_LOAD, idx, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                   1'($urandom_range(0, 1)));
      end else begin
         send_word(ACTION_ENCRYPT, 6'($urandom_range(0, 63)), $urandom,
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end
   endtask

   logic [3:0] round_plan[8] = '{4'd14, 4'd10, 4'd11, 4'd12, 4'd13, 4'd0, 4'd15, 4'd14};

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = ACTION_LOAD;
      req_tlast     = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_rounds(ROUNDS_MAX);
      for (int k = 0; k < 60; k++)
         send_word(ACTION_LOAD, 6'(k), $urandom, '0, '0, 1'b0);
      send_word(ACTION_LOAD, 6'd63, 32'hffff_ffff, '1, '1, 1'b1);
      send_word(ACTION_LOAD, 6'd60, 32'h0, '0, '0, 1'b0);
      send_word(ACTION_ENCRYPT, 6'd0, 32'h0, '0, '0, 1'b0);
      send_word(ACTION_ENCRYPT, 6'd63, 32'hffff_ffff, '1, '1, 1'b1);
      send_word(ACTION_ENCRYPT, 6'd5, 32'h1234_5678, 64'h0123_4567_89ab_cdef,
                64'hfedc_ba98_7654_3210, 1'b0);
      send_word(ACTION_LOAD, 6'd0, 32'h0, '0, '0, 1'b0);
      send_word(ACTION_LOAD, 6'd59, 32'hffff_ffff, '0, '0, 1'b0);
      send_word(ACTION_ENCRYPT, 6'd0, 32'h0, 64'h8000_0000_0000_0001, '1, 1'b1);

      for (int p = 0; p < 8; p++) begin
         write_rounds(round_plan[p]);
         send_idle_pct = (p < 3) ? 7 : (p < 6) ? 85 : 0;
         recv_idle_pct = (p < 3) ? 85 : (p < 6) ? 7 : 0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 6 && n == 20) hold_request = 1'b1;
            if (p == 7 && n == 50) wait_drained();
            send_random();
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("tb_aes_block_encrypt: done, clean");
      end else begin
         $display("tb_aes_block_encrypt: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_cell.sv
hw/rtl/aes_block_encrypt.sv
dv/aes_block_encrypt_checker.sv
dv/tb_aes_block_encrypt.sv
